@@ hdl/sbda_pkg.sv @@
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared constants and types for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbda_pkg;

  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 7;
  localparam int DIGIT_W       = 4;
  localparam int NUM_DIGITS    = 10;
  localparam int TEXT_MAX      = 11;
  localparam int MAX_CHARS_DEF = 12;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  // Per-cycle command shared by every digit cell
  typedef struct packed {
    logic clear;
    logic dabble;
    logic pass;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/sbda_bcd_cell.sv @@
// ----------------------------------------------------------------------------
// sbda_bcd_cell
// One BCD digit of the converter chain: add-3 and shift during conversion,
// digit handoff toward the top of the chain during zero skip and character output.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_bcd_cell (
  input  wire logic                          clk,
  input  wire sbda_pkg::cell_ctl_t           ctl,
  input  wire logic                          bit_in,
  input  wire logic [sbda_pkg::DIGIT_W-1:0]  dig_in,
  output logic      [sbda_pkg::DIGIT_W-1:0]  digit,
  output logic                               carry
);
  import sbda_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  always_comb begin
    adj = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  end

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.dabble) begin
      digit_nxt = {adj[DIGIT_W-2:0], bit_in};
    end else if (ctl.pass) begin
      digit_nxt = dig_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;
  assign carry = adj[DIGIT_W-1];

endmodule

`default_nettype wire

@@ hdl/signed_binary_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed 32-bit value into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_value) takes one two's-complement
//   value per transfer. Output channel (out_valid/out_ready/out_char_code/
//   out_last) returns the text one character per transfer: '-' for a
//   negative value, then the digits of the magnitude, most significant
//   first, no leading zeros. out_last marks the final character; text is
//   cut at MAX_CHARS-1 characters (at most 11).
//   Sequence: accept, bit-serial shift-add-3 conversion through a chain of ten
//   BCD digit cells, dropping of leading zeros, picking of the first
//   character, then one character per cycle while the receiver does not stall.
//   in_ready is high only while idle; the next value is taken as soon as
//   the last character sits in the output register.
//   Reset clears the controller and the output valid; digit cells need none.
//   A stalled receiver holds the output register and pauses the chain during character output.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_binary_to_decimal_ascii #(
  parameter int MAX_CHARS = sbda_pkg::MAX_CHARS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [sbda_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [sbda_pkg::CHAR_W-1:0]   out_char_code,
  output logic                               out_last
);
  import sbda_pkg::*;

  localparam int LIM_RAW  = MAX_CHARS - 1;
  localparam int EMIT_LIM = (LIM_RAW > TEXT_MAX) ? TEXT_MAX : ((LIM_RAW < 1) ? 1 : LIM_RAW);
  localparam int CNT_W    = $clog2(TEXT_MAX + 1);
  localparam int BIT_W    = $clog2(VALUE_W);
  localparam int REM_W    = $clog2(NUM_DIGITS + 1);
  localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(EMIT_LIM - 1);
  localparam logic [BIT_W-1:0] BIT_LAST  = BIT_W'(VALUE_W - 1);
  localparam logic [REM_W-1:0] REM_FULL  = REM_W'(NUM_DIGITS);
  localparam logic [REM_W-1:0] REM_ONE   = REM_W'(1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SKIP  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [VALUE_W-1:0]  mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic [BIT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  cell_ctl_t           ctl;
  logic [DIGIT_W-1:0]  cell_digit [NUM_DIGITS];
  logic                cell_carry [NUM_DIGITS];
  logic [DIGIT_W-1:0]  top_digit;
  logic                in_xfer;
  logic                slot_free;
  logic                hit_last;

  // Digit chain: cell 0 is the least significant digit
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic                bit_in;
    logic [DIGIT_W-1:0]  dig_in;
    if (i == 0) begin : g_first
      assign bit_in = mag_r[VALUE_W-1];
      assign dig_in = '0;
    end else begin : g_rest
      assign bit_in = cell_carry[i-1];
      assign dig_in = cell_digit[i-1];
    end
    sbda_bcd_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .bit_in (bit_in),
      .dig_in (dig_in),
      .digit  (cell_digit[i]),
      .carry  (cell_carry[i])
    );
  end

  assign top_digit = cell_digit[NUM_DIGITS-1];
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign hit_last  = (cnt_r == LAST_IDX);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt     = in_value[VALUE_W-1];
          mag_nxt     = in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                            : VALUE_W'(in_value);
          bit_cnt_nxt = '0;
          cnt_nxt     = '0;
          ctl.clear   = 1'b1;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.dabble  = 1'b1;
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_LAST) begin
          rem_nxt   = REM_FULL;
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if ((top_digit == '0) && (rem_r != REM_ONE)) begin
          ctl.pass = 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = hit_last;
          cnt_nxt       = cnt_r + 1'b1;
          state_nxt     = hit_last ? ST_IDLE : ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + CHAR_W'(top_digit);
          out_last_nxt  = hit_last || (rem_r == REM_ONE);
          ctl.pass      = 1'b1;
          rem_nxt       = rem_r - 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
          if (hit_last || (rem_r == REM_ONE)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  // A 32-bit magnitude always fits in ten decimal digits
  a_no_top_carry : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> !cell_carry[NUM_DIGITS-1])
    else $error("decimal chain overflow");

  a_accept_starts_conv : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_CONV) && (bit_cnt_r == '0))
    else $error("accepted value did not start conversion");

  a_digits_remain : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SKIP) || (state_r == ST_DIGIT)) |-> (rem_r != '0))
    else $error("digit count exhausted");

  a_digit_char : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIGIT) && slot_free) |-> (top_digit <= 4'd9))
    else $error("digit cell holds a non-decimal code");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// A queue of signed values feeds a clocked driver on the input channel. Each
// accepted value is turned into its expected decimal text, one character per
// entry, and every character transfer on the output channel is checked
// against the oldest entry. Directed values hit the extremes, zero, the most
// negative value and several digit counts; random values follow, weighted by digit
// count. Both channels stall at random, except in one long steady window.
// ----------------------------------------------------------------------------

module tb;

  import sbda_pkg::*;

  localparam int NUM_RANDOM = 460;
  localparam int STALL_PCT  = 33;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN      = 60;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [CHAR_W-1:0]         out_char_code;
  logic                      out_last;

  logic signed [VALUE_W-1:0] pending_values[$];
  text_char_t                expected_text[$];
  int                        mismatches = 0;
  int                        cycle_count = 0;
  int                        idle_cycles = 0;
  logic                      steady;

  signed_binary_to_decimal_ascii DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  always #6 clk = ~clk;

  assign steady = (cycle_count >= 12000) && (cycle_count < 18000);

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Expected characters of one value; text is cut at MAX_CHARS_DEF-1 characters (at most TEXT_MAX).
  task automatic push_decimal_text(input logic signed [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  rev_digits[NUM_DIGITS];
    logic [CHAR_W-1:0]  text[TEXT_MAX];
    text_char_t         ch;
    int                 ndig;
    int                 len;
    int                 lim;
    ndig = 0;
    len = 0;
    mag = value[VALUE_W-1] ? (32'd0 - value) : value;
    do begin
      rev_digits[ndig] = CHAR_ZERO + CHAR_W'(mag % 10);
      mag = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < NUM_DIGITS);
    if (value[VALUE_W-1]) begin
      text[len] = CHAR_MINUS;
      len++;
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      text[len] = rev_digits[k];
      len++;
    end
    lim = MAX_CHARS_DEF - 1;
    if (lim > TEXT_MAX) lim = TEXT_MAX;
    if (lim < 1) lim = 1;
    if (len > lim) len = lim;
    for (int k = 0; k < len; k++) begin
      ch.code = text[k];
      ch.last = (k == len - 1);
      expected_text.push_back(ch);
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     ndig;
    logic   neg;
    neg = 1'($urandom_range(1, 0));
    case ($urandom_range(3, 0))
      0: begin
        return $urandom;
      end
      1: begin
        // land next to a power of ten
        ndig = $urandom_range(9, 1);
        mag = 64'd10 ** ndig - $urandom_range(1, 0);
      end
      default: begin
        ndig = $urandom_range(10, 1);
        lo = (ndig == 1) ? 0 : 64'd10 ** (ndig - 1);
        hi = 64'd10 ** ndig - 1;
        if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
        mag = lo + $urandom_range(32'(hi - lo), 0);
      end
    endcase
    return neg ? -VALUE_W'(mag) : VALUE_W'(mag);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_values.size() > 0 && (steady || $urandom_range(99, 0) >= STALL_PCT)) begin
        in_valid <= 1'b1;
        in_value <= pending_values.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99, 0) >= STALL_PCT);
    end
  end

  // Monitor and checker
  always @(posedge clk) begin
    text_char_t exp_ch;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        push_decimal_text(in_value);
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected char %0d last %0b", out_char_code, out_last));
        end else begin
          exp_ch = expected_text.pop_front();
          if (out_char_code !== exp_ch.code) begin
            report_mismatch($sformatf("char_code %0d, expected %0d",
                                      out_char_code, exp_ch.code));
          end
          if (out_last !== exp_ch.last) begin
            report_mismatch($sformatf("last %0b, expected %0b (char %0d)",
                                      out_last, exp_ch.last, exp_ch.code));
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    pending_values = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
      32'sd99, 32'sd100, -32'sd100,
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
      32'sd1000000000, 32'sd999999999, -32'sd1000000000, -32'sd999999999,
      32'sd123456789, -32'sd123456789, 32'sd1999999999,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sd7, 32'sd1234567890
    };
    for (int i = 0; i < NUM_RANDOM; i++) begin
      pending_values.push_back(random_value());
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_values.size() > 0 || in_valid) @(posedge clk);
    while (expected_text.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
